### src/line_edit_receive_buffer_defines.svh
// ----------------------------------------------------------------------------
// line_edit_receive_buffer_defines.svh
// Assertion macros shared by the line edit receive buffer RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_EDIT_RECEIVE_BUFFER_DEFINES_SVH
`define LINE_EDIT_RECEIVE_BUFFER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked property, disabled while reset is high
`define LERB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked property, also during reset
`define LERB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LERB_ASSERT(lbl, clk, rst, prop, msg)
`define LERB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/lerb_pkg.sv
// ----------------------------------------------------------------------------
// lerb_pkg
// Types and constants of the line edit receive buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package lerb_pkg;

   // ring size in bytes (4 .. 4096)
   localparam int DEPTH = 256;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SP = 8'h20;

   typedef enum logic {
      CMD_RX   = 1'b0,
      CMD_READ = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      KIND_ECHO   = 2'd0,
      KIND_READ   = 2'd1,
      KIND_NOLINE = 2'd2
   } kind_type;

   typedef struct packed {
      command_type command;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       line_end;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RDWAIT,
      S_EMIT
   } state_type;

   // which response sequence the current request produces
   typedef enum logic [2:0] {
      SEQ_ECHO,
      SEQ_CR,
      SEQ_BS,
      SEQ_READ,
      SEQ_NOLINE
   } seq_type;

endpackage

`default_nettype wire

### src/line_edit_receive_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_receive_buffer
// Terminal line-editing receive ring buffer with echo.
// ----------------------------------------------------------------------------
// A received byte is stored in a DEPTH-entry ring and echoed; CR is stored,
// counted as a complete line and echoed as CR LF; BS removes the last byte of
// the unfinished line and echoes BS SP BS (nothing if that line is empty).
// A byte arriving with the ring full is dropped silently. A read request
// returns the next stored byte (line_end set on the CR) once a complete line
// is buffered, otherwise one "no line" response. Each response carries last
// on the final one of its request. One request is handled at a time: the
// request side stalls until the final response of a request is issued,
// and a read first waits in a state for the single-port ring memory read.
// A request that produces nothing is accepted without leaving idle. No
// clearing pass is needed after reset: the ring is only read where it has
// been written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_edit_receive_buffer_defines.svh"

module line_edit_receive_buffer
   import lerb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // request channel
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   // response channel
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // ring storage, synchronous read
   logic [7:0] store_mem [DEPTH];
   logic [7:0] mem_q_ff;
   logic       mem_we;
   logic       mem_re;

   // control state
   state_type        state_ff, state_in;
   seq_type          seq_ff, seq_in;
   logic [1:0]       step_ff, step_in;
   logic [7:0]       byte_ff, byte_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] lines_ff, lines_in;
   logic [CNT_W-1:0] open_ff, open_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic    slot_free;
   rsp_type res;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // --- ring memory ---------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_ptr_ff] <= byte_in;
      end
      if (mem_re) begin
         mem_q_ff <= store_mem[rd_ptr_ff];
      end
   end

   // --- response selected by sequence and step ------------------------------
   always_comb begin
      res          = '0;
      res.kind     = KIND_ECHO;
      unique case (seq_ff)
         SEQ_ECHO: begin
            res.data = byte_ff;
            res.last = 1'b1;
         end
         SEQ_CR: begin
            // CR then LF
            res.data = (step_ff == 2'd0) ? CH_CR : CH_LF;
            res.last = (step_ff == 2'd1);
         end
         SEQ_BS: begin
            // BS SP BS rubs out the character on the terminal
            res.data = (step_ff == 2'd1) ? CH_SP : CH_BS;
            res.last = (step_ff == 2'd2);
         end
         SEQ_READ: begin
            res.kind     = KIND_READ;
            res.data     = mem_q_ff;
            res.line_end = (mem_q_ff == CH_CR);
            res.last     = 1'b1;
         end
         SEQ_NOLINE: begin
            res.kind = KIND_NOLINE;
            res.last = 1'b1;
         end
         default: begin
            res.kind = KIND_NOLINE;
            res.last = 1'b1;
         end
      endcase
   end

   // --- next state ----------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      seq_in       = seq_ff;
      step_in      = step_ff;
      byte_in      = byte_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      fill_in      = fill_ff;
      lines_in     = lines_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      req_stall    = (state_ff != S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               byte_in = req_data.rx_byte;
               step_in = 2'd0;
               if (req_data.command == CMD_READ) begin
                  if (lines_ff == '0) begin
                     seq_in   = SEQ_NOLINE;
                     state_in = S_EMIT;
                  end else begin
                     // memory samples the old read pointer at this edge
                     mem_re    = 1'b1;
                     rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
                     fill_in   = fill_ff - 1'b1;
                     seq_in    = SEQ_READ;
                     state_in  = S_RDWAIT;
                  end
               end else if (req_data.rx_byte == CH_BS) begin
                  // empty open line: nothing to rub out
                  if (open_ff != '0) begin
                     wr_ptr_in = (wr_ptr_ff == '0) ? PTR_W'(DEPTH - 1) : wr_ptr_ff - 1'b1;
                     fill_in   = fill_ff - 1'b1;
                     open_in   = open_ff - 1'b1;
                     seq_in    = SEQ_BS;
                     state_in  = S_EMIT;
                  end
               end else if (fill_ff != CNT_W'(DEPTH)) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
                  fill_in   = fill_ff + 1'b1;
                  state_in  = S_EMIT;
                  if (req_data.rx_byte == CH_CR) begin
                     lines_in = lines_ff + 1'b1;
                     open_in  = '0;
                     seq_in   = SEQ_CR;
                  end else begin
                     open_in = open_ff + 1'b1;
                     seq_in  = SEQ_ECHO;
                  end
               end
            end
         end
         S_RDWAIT: begin
            // read data now valid; a CR closes one complete line
            if (mem_q_ff == CH_CR) begin
               lines_in = lines_ff - 1'b1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res;
               if (res.last) begin
                  state_in = S_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // --- registers -----------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         lines_ff     <= '0;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         lines_ff     <= lines_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff  <= seq_in;
      step_ff <= step_in;
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

   // --- assertions ----------------------------------------------------------
   // every buffered CR and every open-line byte sits in the ring; during the
   // read wait the fill has already dropped but the line count not yet
   `LERB_ASSERT(a_lines_fit, clock, reset, (state_ff == S_RDWAIT) || ((lines_ff + open_ff) <= fill_ff), "lines over fill")
   `LERB_ASSERT(a_fill_max, clock, reset, fill_ff <= CNT_W'(DEPTH), "fill beyond ring size")
   // the memory read wait is always followed directly by the emit state
   `LERB_ASSERT(a_rdwait, clock, reset, (state_ff == S_RDWAIT) |=> (state_ff == S_EMIT), "read wait stuck")
   // the final response of a request frees the request side
   `LERB_ASSERT(a_last_idle, clock, reset, (state_ff == S_EMIT && slot_free && res.last) |=> (state_ff == S_IDLE && !req_stall), "no return to idle after last response")
   `LERB_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> (fill_ff == '0 && !rsp_valid_ff), "not empty after reset")

endmodule

`default_nettype wire
